// ----- hw/rtl/hdw_pkg.sv -----
// Shared types and constants for the HD44780 4-bit write sequencer.
package hdw_pkg;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_COMMAND = 3'd2,
    ACT_CURSOR  = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_HOME    = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    CFG_ENABLE_TICKS      = 3'd0,
    CFG_COMMAND_WAIT      = 3'd1,
    CFG_DATA_WAIT         = 3'd2,
    CFG_LONG_WAIT         = 3'd3,
    CFG_BOOT_WAIT         = 3'd4,
    CFG_FIRST_RESET_WAIT  = 3'd5,
    CFG_SHORT_RESET_WAIT  = 3'd6
  } cfg_index_e;

  typedef enum logic [3:0] {
    PH_BOOT  = 4'd0,
    PH_IDLE  = 4'd1,
    PH_SETUP = 4'd2,
    PH_HIGH  = 4'd3,
    PH_WAIT  = 4'd4,
    PH_LONG  = 4'd5
  } phase_e;

  localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
  localparam logic [3:0] INIT_DONE        = 4'd8;
  localparam int unsigned CFG_DATA_W      = 20;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [3:0] bus_nibble;
    logic       reg_select;
    logic       enable_line;
    logic       read_write;
    logic       busy_res;
    logic       accepted;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [2:0]            reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_write_t;

  typedef struct packed {
    logic [7:0]  enable_ticks;
    logic [15:0] command_wait_ticks;
    logic [15:0] data_wait_ticks;
    logic [19:0] long_wait_ticks;
    logic [19:0] boot_wait_ticks;
    logic [19:0] first_reset_wait_ticks;
    logic [19:0] short_reset_wait_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] init_step;
    logic [7:0] pending_byte;
    logic       low_nibble_pending;
    logic       extra_long_wait;
    logic       select_level;
    logic [3:0] nibble_level;
  } seq_state_t;

endpackage

// ----- hw/rtl/hdw_if.sv -----
// Valid/ready channel interfaces for input items, result items and config writes.
interface hdw_in_if
  import hdw_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hdw_out_if
  import hdw_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hdw_cfg_if
  import hdw_pkg::*;
();
  logic       valid;
  logic       ready;
  cfg_write_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/hdw_cfg_regs.sv -----
// Timing configuration register file with reset defaults.
module hdw_cfg_regs
  import hdw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cfg_write_t wr,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr.reg_index)
        CFG_ENABLE_TICKS:     cfg_nxt.enable_ticks           = wr.wr_data[7:0];
        CFG_COMMAND_WAIT:     cfg_nxt.command_wait_ticks     = wr.wr_data[15:0];
        CFG_DATA_WAIT:        cfg_nxt.data_wait_ticks        = wr.wr_data[15:0];
        CFG_LONG_WAIT:        cfg_nxt.long_wait_ticks        = wr.wr_data[19:0];
        CFG_BOOT_WAIT:        cfg_nxt.boot_wait_ticks        = wr.wr_data[19:0];
        CFG_FIRST_RESET_WAIT: cfg_nxt.first_reset_wait_ticks = wr.wr_data[19:0];
        CFG_SHORT_RESET_WAIT: cfg_nxt.short_reset_wait_ticks = wr.wr_data[19:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_ticks           <= 8'd1;
      cfg_r.command_wait_ticks     <= 16'd50;
      cfg_r.data_wait_ticks        <= 16'd50;
      cfg_r.long_wait_ticks        <= 20'd2000;
      cfg_r.boot_wait_ticks        <= 20'd15000;
      cfg_r.first_reset_wait_ticks <= 20'd5000;
      cfg_r.short_reset_wait_ticks <= 20'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/hdw_sequencer.sv -----
// Sequencer state, wait counter and per-item next-state and line logic.
module hdw_sequencer
  import hdw_pkg::*;
#(
  parameter int unsigned WAIT_COUNTER_WIDTH = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      item_take,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int unsigned W = WAIT_COUNTER_WIDTH;
  localparam logic [31:0] CNT_MAX = 32'((64'd1 << W) - 64'd1);
  localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h0F, 8'h06, 8'h01};

  seq_state_t st_r, st_nxt;
  logic [W-1:0] cnt_r, cnt_nxt;

  function automatic seq_state_t start_byte(seq_state_t st, logic [7:0] b, logic rs,
                                            logic lw);
    seq_state_t o;
    o                    = st;
    o.pending_byte       = b;
    o.select_level       = rs;
    o.extra_long_wait    = lw;
    o.low_nibble_pending = 1'b1;
    o.nibble_level       = 4'((b & HIGH_NIBBLE_MASK) >> 4);
    o.phase              = PH_SETUP;
    return o;
  endfunction

  function automatic seq_state_t start_init(seq_state_t st);
    seq_state_t o;
    o = st;
    if (st.init_step < 4'd4) begin
      o.select_level       = 1'b0;
      o.extra_long_wait    = 1'b0;
      o.low_nibble_pending = 1'b0;
      o.nibble_level       = (st.init_step == 4'd3) ? 4'h2 : 4'h3;
      o.phase              = PH_SETUP;
    end else begin
      o = start_byte(st, INIT_BYTES[st.init_step[1:0]], 1'b0, st.init_step == 4'd7);
    end
    return o;
  endfunction

  function automatic seq_state_t finish_item(seq_state_t st);
    seq_state_t o;
    o = st;
    o.extra_long_wait = 1'b0;
    if (st.init_step < INIT_DONE) begin
      o.init_step = st.init_step + 4'd1;
      if (o.init_step >= INIT_DONE) o.phase = PH_IDLE;
      else o = start_init(o);
    end else begin
      o.phase = PH_IDLE;
    end
    return o;
  endfunction

  seq_state_t   s;
  logic [W-1:0] cnt, cnt_inc;
  logic         is_req, reached;
  logic [19:0]  tgt_raw;
  logic [31:0]  tgt;

  always_comb begin
    s       = st_r;
    cnt     = cnt_r;
    result  = '0;
    is_req  = 1'b0;
    tgt_raw = '0;

    case (item.action) inside
      ACT_DATA, ACT_COMMAND, ACT_CLEAR, ACT_HOME: is_req = 1'b1;
      ACT_CURSOR: is_req = (item.row <= 2'd1);
      default:    is_req = 1'b0;
    endcase

    // Take or reject the request first; a taken one shows its setup tick now.
    if (is_req) begin
      if (st_r.phase == PH_IDLE) begin
        result.accepted = 1'b1;
        cnt = '0;
        unique case (item.action)
          ACT_DATA:    s = start_byte(st_r, item.byte_value, 1'b1, 1'b0);
          ACT_COMMAND: s = start_byte(st_r, item.byte_value, 1'b0, 1'b0);
          ACT_CURSOR:  s = start_byte(st_r,
                             8'h80 | (item.row[0] ? 8'h40 : 8'h00) | {2'b00, item.column},
                             1'b0, 1'b0);
          ACT_CLEAR:   s = start_byte(st_r, 8'h01, 1'b0, 1'b1);
          default:     s = start_byte(st_r, 8'h02, 1'b0, 1'b1);
        endcase
      end else begin
        result.rejected = 1'b1;
      end
    end

    result.bus_nibble  = s.nibble_level;
    result.reg_select  = s.select_level;
    result.enable_line = (s.phase == PH_HIGH);
    result.read_write  = 1'b0;

    // One shared tick counter: pick this phase's target, clamp, compare.
    unique case (s.phase)
      PH_BOOT: tgt_raw = cfg.boot_wait_ticks;
      PH_HIGH: tgt_raw = {12'd0, cfg.enable_ticks};
      PH_WAIT: begin
        if (s.init_step < INIT_DONE) begin
          if (s.init_step == 4'd0)     tgt_raw = cfg.first_reset_wait_ticks;
          else if (s.init_step < 4'd4) tgt_raw = cfg.short_reset_wait_ticks;
          else                         tgt_raw = {4'd0, cfg.command_wait_ticks};
        end else begin
          tgt_raw = s.select_level ? {4'd0, cfg.data_wait_ticks}
                                   : {4'd0, cfg.command_wait_ticks};
        end
      end
      PH_LONG: tgt_raw = cfg.long_wait_ticks;
      default: tgt_raw = '0;
    endcase
    tgt = {12'd0, tgt_raw};
    if (tgt > CNT_MAX) tgt = CNT_MAX;
    if (tgt == 32'd0)  tgt = 32'd1;
    cnt_inc = (cnt != {W{1'b1}}) ? cnt + 1'b1 : cnt;
    reached = (32'(cnt_inc) >= tgt);

    unique case (s.phase)
      PH_BOOT: begin
        if (reached) begin
          s.init_step = 4'd0;
          s   = start_init(s);
          cnt = '0;
        end else cnt = cnt_inc;
      end
      PH_IDLE: ;
      PH_SETUP: begin
        s.phase = PH_HIGH;
        cnt     = '0;
      end
      PH_HIGH: begin
        if (reached) begin
          cnt = '0;
          if (s.low_nibble_pending) begin
            s.low_nibble_pending = 1'b0;
            s.nibble_level       = s.pending_byte[3:0];
            s.phase              = PH_SETUP;
          end else begin
            s.phase = PH_WAIT;
          end
        end else cnt = cnt_inc;
      end
      PH_WAIT: begin
        if (reached) begin
          cnt = '0;
          if (s.extra_long_wait) s.phase = PH_LONG;
          else s = finish_item(s);
        end else cnt = cnt_inc;
      end
      PH_LONG: begin
        if (reached) begin
          cnt = '0;
          s   = finish_item(s);
        end else cnt = cnt_inc;
      end
      default: s.phase = PH_IDLE;
    endcase

    result.busy_res = (s.phase != PH_IDLE);
    st_nxt  = s;
    cnt_nxt = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{phase: PH_BOOT, default: '0};
      cnt_r <= '0;
    end else if (item_take) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/hd44780_4bit_write_sequencer_core.sv -----
// Top level of the HD44780 4-bit write sequencer: handshake, result register, config.
// Throughput: one item per cycle; an item is taken whenever the result register is
//   empty or its result is being taken in the same cycle.
// The result item for an accepted input appears at out_if in the next cycle.
// Sequencer phase, init step and wait counter advance only on accepted items.
// Reset (rst_n, synchronous, active low) empties the result register, restores the
//   timing registers to their defaults and puts the sequencer in its boot wait.
module hd44780_4bit_write_sequencer_core
  import hdw_pkg::*;
#(
  parameter int unsigned WAIT_COUNTER_WIDTH = 20
) (
  input logic       clk,
  input logic       rst_n,
  hdw_in_if.sink    in_if,
  hdw_out_if.source out_if,
  hdw_cfg_if.sink   cfg_if
);

  cfg_t      cfg;
  out_item_t result;
  out_item_t res_r;
  logic      out_valid_r, out_valid_nxt;
  logic      in_take;

  // Config is always ready; software writes must come only while the block is idle.
  assign cfg_if.ready = 1'b1;

  hdw_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_if.valid & cfg_if.ready),
    .wr    (cfg_if.payload),
    .cfg   (cfg)
  );

  // Accept a new item while the result register is empty or drains: it is the only
  // buffer between the two sides, so ready just looks at its occupancy.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_take     = in_if.valid && in_if.ready;

  // The sequencer computes the lines and flags for this item from its state
  // and commits its next state only on the accept edge.
  hdw_sequencer #(
    .WAIT_COUNTER_WIDTH (WAIT_COUNTER_WIDTH)
  ) u_sequencer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_take (in_take),
    .item      (in_if.payload),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take)           out_valid_nxt = 1'b1;
    else if (out_if.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; hold it until the next item replaces it.
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= result;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = res_r;

  // A request is either taken or turned away, never both.
  a_acc_rej_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.accepted && res_r.rejected))
    else $error("result flags both accepted and rejected");

  // A taken request leaves the sequencer busy on its own result.
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.accepted) |-> res_r.busy_res)
    else $error("accepted request reported idle");

  // Enable high means a nibble is in flight, so the block cannot be idle after it.
  a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.enable_line) |-> res_r.busy_res)
    else $error("enable strobe with idle sequencer");

  // A stalled result blocks the input, so no result is overwritten.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while result register is stalled");

  // An accepted item always produces a result on the next cycle.
  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule

// ----- tb/hd44780_4bit_write_sequencer_core_tb.sv -----
// Self-checking testbench for the HD44780 4-bit write sequencer core.
`timescale 1ns / 1ps

module hd44780_4bit_write_sequencer_core_tb;
  import hdw_pkg::*;

  localparam int unsigned WCW       = 20;     // wait counter width handed to the core
  localparam int unsigned HALF_CLK  = 6;
  localparam int unsigned STALL_CAP = 4000;   // cycles without any handshake
  localparam int unsigned SETTLE_CHUNK = 16;  // ticks queued per round while waiting for idle

  // Codes the package does not name
  localparam logic [2:0] ACT_SPARE_LO    = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI    = 3'd7;
  localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;

  // Init sequence and command bytes
  localparam logic [3:0] SOFT_RESET_NIBBLE = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE   = 4'h2;
  localparam logic [3:0] FOUR_BIT_STEP     = 4'd3;
  localparam logic [3:0] FIRST_BYTE_STEP   = 4'd4;
  localparam logic [3:0] CLEAR_STEP        = 4'd7;
  localparam logic [7:0] CMD_FUNCTION_SET  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0F;
  localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;
  localparam logic [7:0] CMD_CLEAR         = 8'h01;
  localparam logic [7:0] CMD_HOME          = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR      = 8'h80;
  localparam logic [7:0] ROW1_OFFSET       = 8'h40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hdw_in_if  in_if ();
  hdw_out_if out_if ();
  hdw_cfg_if cfg_if ();

  hd44780_4bit_write_sequencer_core #(
    .WAIT_COUNTER_WIDTH(WCW)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always #(HALF_CLK) clk = ~clk;

  // Items waiting to be offered, and bus states predicted for items already taken
  in_item_t  pending_requests[$];
  out_item_t expected_bus[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned errors        = 0;
  int unsigned items_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned req_taken     = 0;
  int unsigned req_refused   = 0;
  int unsigned reg_writes    = 0;

  // ---------------------------------------------------------------------------
  // Sequencer shadow: timing registers and state, advanced once per taken item
  // ---------------------------------------------------------------------------
  cfg_t           lcd_cfg;
  phase_e         lcd_phase;
  logic [3:0]     lcd_init_step;
  logic [WCW-1:0] lcd_wait_count;
  logic [7:0]     lcd_pending_byte;
  logic           lcd_low_pending;
  logic           lcd_long_pending;
  logic           lcd_select;
  logic [3:0]     lcd_nibble;

  // Count one tick against a target; zero acts as one, oversized targets clip to the
  // counter's range and the counter itself saturates.
  function automatic bit count_tick(longint unsigned target);
    longint unsigned cmax;
    cmax = (64'd1 << WCW) - 1;
    if (target > cmax) target = cmax;
    if (target == 0) target = 1;
    if (lcd_wait_count < cmax) lcd_wait_count = lcd_wait_count + 1'b1;
    return (lcd_wait_count >= target);
  endfunction

  // Load a byte: upper nibble first, low nibble flagged for later
  function automatic void load_byte(logic [7:0] b, logic rs, logic long_after);
    lcd_pending_byte = b;
    lcd_select       = rs;
    lcd_long_pending = long_after;
    lcd_low_pending  = 1'b1;
    lcd_nibble       = 4'((b & HIGH_NIBBLE_MASK) >> 4);
    lcd_phase        = PH_SETUP;
    lcd_wait_count   = '0;
  endfunction

  // Start whatever the current init step sends: a lone nibble, or a full command
  function automatic void load_init_item();
    if (lcd_init_step < FIRST_BYTE_STEP) begin
      lcd_select       = 1'b0;
      lcd_long_pending = 1'b0;
      lcd_low_pending  = 1'b0;
      lcd_nibble       = (lcd_init_step == FOUR_BIT_STEP) ? FOUR_BIT_NIBBLE : SOFT_RESET_NIBBLE;
      lcd_phase        = PH_SETUP;
      lcd_wait_count   = '0;
    end else begin
      case (lcd_init_step[1:0])
        2'd0:    load_byte(CMD_FUNCTION_SET, 1'b0, 1'b0);
        2'd1:    load_byte(CMD_DISPLAY_ON, 1'b0, 1'b0);
        2'd2:    load_byte(CMD_ENTRY_MODE, 1'b0, 1'b0);
        default: load_byte(CMD_CLEAR, 1'b0, lcd_init_step == CLEAR_STEP);
      endcase
    end
  endfunction

  // End of one item's waits: step the init sequence or fall back to idle
  function automatic void close_item();
    lcd_long_pending = 1'b0;
    lcd_wait_count   = '0;
    if (lcd_init_step < INIT_DONE) begin
      lcd_init_step = lcd_init_step + 1'b1;
      if (lcd_init_step >= INIT_DONE) lcd_phase = PH_IDLE;
      else load_init_item();
    end else begin
      lcd_phase = PH_IDLE;
    end
  endfunction

  // Predict the bus state for one taken item, then let one tick elapse
  function automatic out_item_t predict_bus_tick(in_item_t it);
    out_item_t       r;
    logic            is_req;
    longint unsigned target;
    is_req = (it.action >= ACT_DATA) && (it.action <= ACT_HOME) &&
             !((it.action == ACT_CURSOR) && (it.row > 2'd1));
    r = '0;
    // take or turn away the request first; a taken one shows its setup tick at once
    if (is_req) begin
      if (lcd_phase == PH_IDLE) begin
        r.accepted = 1'b1;
        case (action_e'(it.action))
          ACT_DATA:    load_byte(it.byte_value, 1'b1, 1'b0);
          ACT_COMMAND: load_byte(it.byte_value, 1'b0, 1'b0);
          ACT_CURSOR:  load_byte(8'(CMD_SET_ADDR + (it.row[0] ? ROW1_OFFSET : 8'h00) +
                                    {2'b00, it.column}), 1'b0, 1'b0);
          ACT_CLEAR:   load_byte(CMD_CLEAR, 1'b0, 1'b1);
          default:     load_byte(CMD_HOME, 1'b0, 1'b1);
        endcase
      end else begin
        r.rejected = 1'b1;
      end
    end
    r.bus_nibble  = lcd_nibble;
    r.reg_select  = lcd_select;
    r.enable_line = (lcd_phase == PH_HIGH);
    r.read_write  = 1'b0;

    case (lcd_phase)
      PH_BOOT: begin
        if (count_tick(64'(lcd_cfg.boot_wait_ticks))) begin
          lcd_init_step = '0;
          load_init_item();
        end
      end
      PH_SETUP: begin
        lcd_phase      = PH_HIGH;
        lcd_wait_count = '0;
      end
      PH_HIGH: begin
        if (count_tick(64'(lcd_cfg.enable_ticks))) begin
          lcd_wait_count = '0;
          if (lcd_low_pending) begin
            lcd_low_pending = 1'b0;
            lcd_nibble      = lcd_pending_byte[3:0];
            lcd_phase       = PH_SETUP;
          end else begin
            lcd_phase = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        // init nibbles have their own waits; afterwards the select line picks the wait
        if (lcd_init_step < INIT_DONE) begin
          if (lcd_init_step == 4'd0)
            target = 64'(lcd_cfg.first_reset_wait_ticks);
          else if (lcd_init_step < FIRST_BYTE_STEP)
            target = 64'(lcd_cfg.short_reset_wait_ticks);
          else
            target = 64'(lcd_cfg.command_wait_ticks);
        end else begin
          target = lcd_select ? 64'(lcd_cfg.data_wait_ticks)
                              : 64'(lcd_cfg.command_wait_ticks);
        end
        if (count_tick(target)) begin
          lcd_wait_count = '0;
          if (lcd_long_pending) lcd_phase = PH_LONG;
          else close_item();
        end
      end
      PH_LONG: begin
        if (count_tick(64'(lcd_cfg.long_wait_ticks))) close_item();
      end
      default: lcd_phase = PH_IDLE;
    endcase

    r.busy_res = (lcd_phase != PH_IDLE);
    return r;
  endfunction

  function automatic string show_bus(out_item_t r);
    return $sformatf("nib=%h rs=%b en=%b rw=%b busy=%b acc=%b rej=%b", r.bus_nibble,
                     r.reg_select, r.enable_line, r.read_write, r.busy_res, r.accepted,
                     r.rejected);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the oldest pending item, hold it until taken, idle at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_bus.push_back(predict_bus_tick(in_if.payload));
        if (expected_bus[$].accepted) req_taken++;
        if (expected_bus[$].rejected) req_refused++;
        void'(pending_requests.pop_front());
        items_taken++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold: the item stays on the bus until the core takes it
      end else if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid   <= 1'b1;
        in_if.payload <= pending_requests[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every result item with the oldest prediction, stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : bus_monitor
    out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_bus.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t ns: result item with nothing outstanding: %s", $time,
                     show_bus(out_if.payload));
        end else begin
          want = expected_bus.pop_front();
          if (out_if.payload !== want) begin
            errors++;
            if (errors <= 20)
              $display("%0t ns: result item %0d mismatch: expected %s, actual %s", $time,
                       results_seen, show_bus(want), show_bus(out_if.payload));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run once no channel has moved for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < STALL_CAP) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no handshake for %0d cycles", $time, STALL_CAP);
    $display("hd44780_4bit_write_sequencer_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(logic [2:0] act, logic [7:0] b, logic [5:0] col,
                                     logic [1:0] row);
    in_item_t it;
    it.action     = act;
    it.byte_value = b;
    it.column     = col;
    it.row        = row;
    pending_requests.push_back(it);
  endfunction

  // Plain ticks; the other fields carry junk that must be ignored
  function automatic void queue_ticks(int unsigned n);
    repeat (n) queue_item(ACT_TICK, 8'($urandom), 6'($urandom), 2'($urandom));
  endfunction

  // Wait until every pending item is taken and every result has come back
  task automatic wait_for_drain();
    do @(posedge clk); while (pending_requests.size() != 0 || expected_bus.size() != 0);
  endtask

  // Feed ticks until the shadow says the sequencer is idle again
  task automatic run_until_idle();
    wait_for_drain();
    while (lcd_phase != PH_IDLE) begin
      queue_ticks(SETTLE_CHUNK);
      wait_for_drain();
    end
  endtask

  // One request offered on an idle sequencer, then run it to completion
  task automatic issue(logic [2:0] act, logic [7:0] b, logic [5:0] col, logic [1:0] row);
    queue_item(act, b, col, row);
    run_until_idle();
  endtask

  // Write one timing register; the shadow copy keeps only the register's width
  task automatic write_timing_reg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{reg_index: idx, wr_data: val};
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      CFG_ENABLE_TICKS:     lcd_cfg.enable_ticks           = val[7:0];
      CFG_COMMAND_WAIT:     lcd_cfg.command_wait_ticks     = val[15:0];
      CFG_DATA_WAIT:        lcd_cfg.data_wait_ticks        = val[15:0];
      CFG_LONG_WAIT:        lcd_cfg.long_wait_ticks        = val;
      CFG_BOOT_WAIT:        lcd_cfg.boot_wait_ticks        = val;
      CFG_FIRST_RESET_WAIT: lcd_cfg.first_reset_wait_ticks = val;
      CFG_SHORT_RESET_WAIT: lcd_cfg.short_reset_wait_ticks = val;
      default: ;
    endcase
    reg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // Random short timings; junk above the enable, command and data wait widths must be dropped
  task automatic randomize_timing(int unsigned max_en, int unsigned max_wait,
                                  int unsigned max_long);
    write_timing_reg(CFG_ENABLE_TICKS, {12'($urandom), 8'($urandom_range(0, max_en))});
    write_timing_reg(CFG_COMMAND_WAIT, {4'($urandom), 16'($urandom_range(0, max_wait))});
    write_timing_reg(CFG_DATA_WAIT, {4'($urandom), 16'($urandom_range(0, max_wait))});
    write_timing_reg(CFG_LONG_WAIT, 20'($urandom_range(0, max_long)));
  endtask

  // Mostly ticks so that requests land on an idle sequencer often enough; the rest
  // are requests of every kind, spare actions and cursor moves to bad rows.
  task automatic queue_random_items(int unsigned n);
    in_item_t    it;
    int unsigned pick;
    repeat (n) begin
      it.byte_value = 8'($urandom);
      it.column     = 6'($urandom);
      it.row        = 2'($urandom);
      pick          = $urandom_range(99);
      if (pick < 55)      it.action = ACT_TICK;
      else if (pick < 60) it.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      else                it.action = 3'($urandom_range(ACT_DATA, ACT_HOME));
      if (it.action == ACT_CURSOR && $urandom_range(99) < 75) it.row[1] = 1'b0;
      pending_requests.push_back(it);
    end
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;

    // shadow starts from the core's reset state
    lcd_cfg.enable_ticks           = 8'd1;
    lcd_cfg.command_wait_ticks     = 16'd50;
    lcd_cfg.data_wait_ticks        = 16'd50;
    lcd_cfg.long_wait_ticks        = 20'd2000;
    lcd_cfg.boot_wait_ticks        = 20'd15000;
    lcd_cfg.first_reset_wait_ticks = 20'd5000;
    lcd_cfg.short_reset_wait_ticks = 20'd1000;
    lcd_phase        = PH_BOOT;
    lcd_init_step    = '0;
    lcd_wait_count   = '0;
    lcd_pending_byte = '0;
    lcd_low_pending  = 1'b0;
    lcd_long_pending = 1'b0;
    lcd_select       = 1'b0;
    lcd_nibble       = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- sender idles 28%, receiver stalls 46% ---
    send_idle_pct  = 28;
    recv_stall_pct = 46;

    // shorten boot and init so the run reaches idle quickly; also poke the spare index
    write_timing_reg(CFG_ENABLE_TICKS, 20'd1);
    write_timing_reg(CFG_COMMAND_WAIT, 20'd2);
    write_timing_reg(CFG_DATA_WAIT, 20'd3);
    write_timing_reg(CFG_LONG_WAIT, 20'd5);
    write_timing_reg(CFG_BOOT_WAIT, 20'd4);
    write_timing_reg(CFG_FIRST_RESET_WAIT, 20'd3);
    write_timing_reg(CFG_SHORT_RESET_WAIT, 20'd2);
    write_timing_reg(CFG_SPARE_INDEX, 20'hFFFFF);

    // requests during boot and during init are turned away
    queue_item(ACT_DATA, 8'hFF, 6'h3F, 2'd3);
    queue_ticks(12);
    queue_item(ACT_HOME, 8'h00, 6'h00, 2'd0);
    run_until_idle();

    // directed requests on an idle sequencer: field extremes and every action
    issue(ACT_DATA, 8'h00, 6'h00, 2'd0);
    issue(ACT_DATA, 8'hFF, 6'h3F, 2'd3);
    issue(ACT_COMMAND, 8'h00, 6'h3F, 2'd3);
    issue(ACT_COMMAND, 8'hFF, 6'h00, 2'd0);
    issue(ACT_CURSOR, 8'hFF, 6'h00, 2'd0);
    issue(ACT_CURSOR, 8'h00, 6'h3F, 2'd1);
    issue(ACT_CURSOR, 8'h00, 6'h05, 2'd2);  // bad row: plain tick
    issue(ACT_CURSOR, 8'hFF, 6'h3F, 2'd3);  // bad row: plain tick
    issue(ACT_CLEAR, 8'hFF, 6'h3F, 2'd3);
    issue(ACT_HOME, 8'h00, 6'h00, 2'd0);
    issue(ACT_SPARE_LO, 8'hFF, 6'h3F, 2'd1);
    issue(ACT_SPARE_HI, 8'h00, 6'h00, 2'd0);
    // back-to-back requests: the second arrives while busy
    queue_item(ACT_DATA, 8'h5A, 6'h00, 2'd0);
    queue_item(ACT_COMMAND, 8'hA5, 6'h00, 2'd0);
    run_until_idle();

    randomize_timing(2, 4, 8);
    queue_random_items(250);

    // enable, command, data and long wait registers at zero, which must act as one
    run_until_idle();
    write_timing_reg(CFG_ENABLE_TICKS, 20'd0);
    write_timing_reg(CFG_COMMAND_WAIT, 20'd0);
    write_timing_reg(CFG_DATA_WAIT, 20'd0);
    write_timing_reg(CFG_LONG_WAIT, 20'd0);
    queue_random_items(200);

    // --- sender idles 46%, receiver stalls 28% ---
    run_until_idle();
    send_idle_pct  = 46;
    recv_stall_pct = 28;

    // widest enable pulse, reached through junk in the upper write bits
    write_timing_reg(CFG_ENABLE_TICKS, 20'hABCFF);
    write_timing_reg(CFG_COMMAND_WAIT, 20'd1);
    write_timing_reg(CFG_DATA_WAIT, 20'd2);
    write_timing_reg(CFG_LONG_WAIT, 20'd3);
    queue_random_items(150);

    run_until_idle();
    randomize_timing(4, 20, 300);
    queue_random_items(300);

    // --- no idling on either side ---
    run_until_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // junk above the width of the enable and byte wait registers; boot and init
    // waits at their top no longer matter, and no clear or home runs while the
    // long wait sits at its maximum
    write_timing_reg(CFG_ENABLE_TICKS, 20'hFFF02);
    write_timing_reg(CFG_COMMAND_WAIT, 20'hF0006);
    write_timing_reg(CFG_DATA_WAIT, 20'h30005);
    write_timing_reg(CFG_LONG_WAIT, 20'hFFFFF);
    write_timing_reg(CFG_BOOT_WAIT, 20'hFFFFF);
    write_timing_reg(CFG_FIRST_RESET_WAIT, 20'hFFFFF);
    write_timing_reg(CFG_SHORT_RESET_WAIT, 20'hFFFFF);
    issue(ACT_DATA, 8'hC3, 6'h00, 2'd0);
    issue(ACT_COMMAND, 8'h3C, 6'h00, 2'd0);

    randomize_timing(6, 12, 40);
    queue_random_items(250);
    run_until_idle();

    // let the registered result path empty out, watching for strays
    repeat (8) @(posedge clk);
    if (expected_bus.size() != 0) begin
      errors++;
      $display("%0t ns: %0d predicted result items never arrived", $time, expected_bus.size());
    end

    $display("Ran %0d items through the core and checked %0d result items, %0d mismatching.",
             items_taken, results_seen, errors);
    $display("Requests taken %0d, turned away %0d; %0d timing register writes.",
             req_taken, req_refused, reg_writes);
    if (errors == 0) begin
      $display("hd44780_4bit_write_sequencer_core regression: pass");
    end else begin
      $display("hd44780_4bit_write_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule
